>>> hw/rtl/psm_pkg.sv
// Package for the pulse speed meter: request and result types, register
// indexes, operation codes and arithmetic constants.
// Used by every module of the block; depends on nothing.
package psm_pkg;

  localparam int unsigned TimeW   = 16;
  localparam int unsigned CountW  = 16;
  localparam int unsigned SpeedW  = 16;
  localparam int unsigned MileW   = 32;
  localparam int unsigned ScaleW  = 32;
  localparam int unsigned ProdW   = ScaleW + CountW;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgW    = 32;

  // Quotient bits produced by the shift-subtract divider.
  localparam int unsigned DivSteps = SpeedW;
  localparam int unsigned StepW    = $clog2(DivSteps);

  localparam logic [SpeedW-1:0] SPEED_SAT  = 16'hFFFF;
  localparam logic [SpeedW-1:0] MIN_MOVING = 16'd100;
  localparam logic [CountW-1:0] COUNT_MAX  = 16'hFFFF;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] CFG_SPEED_SCALE    = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_ZERO_SPEED_GAP = 1'b1;

  // Operation codes of an input request.
  localparam logic OP_PULSE = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  typedef struct packed {
    logic              operation;
    logic [TimeW-1:0]  timer_now;
  } psm_in_t;

  typedef struct packed {
    logic [SpeedW-1:0] speed;
    logic [MileW-1:0]  mileage;
    logic              speed_updated;
  } psm_out_t;

  // Start request to the divider.
  typedef struct packed {
    logic              start;
    logic [ScaleW-1:0] scale;
    logic [CountW-1:0] count;
    logic [TimeW-1:0]  elapsed;
  } psm_div_req_t;

  // Completion from the divider.
  typedef struct packed {
    logic              done;
    logic [SpeedW-1:0] quotient;
  } psm_div_rsp_t;

endpackage

>>> hw/rtl/pulse_speed_meter_top.sv
// Pulse speed meter top level. A pulse, or a tick that needs no quotient, is answered
// in the cycle after acceptance. A tick that needs a quotient passes the multiply,
// the overflow check and, unless that saturates, 16 steps of the divider. One
// request is in flight at a time; the next is taken as the result register empties.
// rst_ni is asynchronous and active low; it clears the meter state but for the tick
// timestamp and result payload, speed_scale to 0 and zero_speed_gap to 65535.
module pulse_speed_meter_top (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  psm_pkg::psm_in_t                        in_data_i,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output psm_pkg::psm_out_t                       out_data_o,
  input  logic                                    cfg_we_i,
  input  logic [psm_pkg::CfgIdxW-1:0]             cfg_idx_i,
  input  logic [psm_pkg::CfgW-1:0]                cfg_wdata_i
);
  import psm_pkg::*;

  // The sequencer either waits for a request or waits on the divider.
  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DIV  = 2'b10
  } seq_state_e;

  seq_state_e        state_q, state_d;

  // Configuration registers.
  logic [ScaleW-1:0] scale_q;
  logic [TimeW-1:0]  gap_q;

  // Architectural state of the meter.
  logic [TimeW-1:0]  last_q, last_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic [TimeW-1:0]  prev_q, prev_d;
  logic [SpeedW-1:0] speed_q, speed_d;
  logic [MileW-1:0]  total_q, total_d;

  // Tick context kept while the divider runs.
  logic              had_q, had_d;
  logic [TimeW-1:0]  now_q, now_d;

  // Result register that separates the two channels.
  logic              out_valid_q, out_valid_d;
  psm_out_t          out_q, out_d;

  psm_div_req_t      div_req;
  psm_div_rsp_t      div_rsp;

  logic              in_acc;
  logic              had_pulses;
  logic              need_div;
  logic [SpeedW-1:0] spd;
  logic              wr;

  // A new request is taken only when idle and the result register is free
  // or is being emptied in this cycle.
  assign in_stall_o = (state_q != S_IDLE) || (out_valid_q && out_stall_i);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign had_pulses = (cnt_q != '0);
  assign need_div   = had_pulses || (speed_q != '0);

  // With pending pulses the interval runs between the last two stamps;
  // without, one pulse is assumed at the current time.
  assign div_req.start   = in_acc && (in_data_i.operation == OP_TICK) && need_div;
  assign div_req.scale   = scale_q;
  assign div_req.count   = had_pulses ? cnt_q : CountW'(1);
  assign div_req.elapsed = (had_pulses ? last_q : in_data_i.timer_now) - prev_q;

  psm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Final speed decision once the quotient is known.
  always_comb begin
    spd = div_rsp.quotient;
    wr  = 1'b1;
    if (had_q) begin
      // Moving: never report below 1 km/h.
      if (div_rsp.quotient < MIN_MOVING) begin
        spd = MIN_MOVING;
      end
    end else if (div_rsp.quotient < MIN_MOVING) begin
      // No pulses and slower than 1 km/h: the vehicle is taken as stopped.
      spd = '0;
    end else if (div_rsp.quotient > speed_q) begin
      // No pulses can only lower the speed, never raise it.
      wr = 1'b0;
    end
  end

  always_comb begin
    state_d     = state_q;
    last_d      = last_q;
    cnt_d       = cnt_q;
    prev_d      = prev_q;
    speed_d     = speed_q;
    total_d     = total_q;
    had_d       = had_q;
    now_d       = now_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_data_i.operation == OP_PULSE) begin
            last_d = in_data_i.timer_now;
            if (cnt_q != COUNT_MAX) begin
              cnt_d = cnt_q + 1'b1;
            end
            out_d.speed         = speed_q;
            out_d.mileage       = total_q;
            out_d.speed_updated = 1'b0;
            out_valid_d         = 1'b1;
          end else begin
            cnt_d = '0;
            if (!need_div) begin
              // Already stopped: keep zero and back-date the previous stamp.
              prev_d              = last_q - gap_q;
              speed_d             = '0;
              out_d.speed         = '0;
              out_d.mileage       = total_q;
              out_d.speed_updated = 1'b1;
              out_valid_d         = 1'b1;
            end else begin
              if (had_pulses) begin
                total_d = total_q + MileW'(cnt_q);
                prev_d  = last_q;
              end
              had_d   = had_pulses;
              now_d   = in_data_i.timer_now;
              state_d = S_DIV;
            end
          end
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          if (!had_q && (div_rsp.quotient < MIN_MOVING)) begin
            prev_d = now_q - gap_q;
          end
          if (wr) begin
            speed_d = spd;
          end
          out_d.speed         = wr ? spd : speed_q;
          out_d.mileage       = total_q;
          out_d.speed_updated = wr;
          out_valid_d         = 1'b1;
          state_d             = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      last_q      <= '0;
      cnt_q       <= '0;
      prev_q      <= '0;
      speed_q     <= '0;
      total_q     <= '0;
      had_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      last_q      <= last_d;
      cnt_q       <= cnt_d;
      prev_q      <= prev_d;
      speed_q     <= speed_d;
      total_q     <= total_d;
      had_q       <= had_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Tick timestamp and result payload need no reset.
  always_ff @(posedge clk_i) begin
    now_q <= now_d;
    out_q <= out_d;
  end

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= '0;
      gap_q   <= SPEED_SAT;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SPEED_SCALE: begin
          scale_q <= cfg_wdata_i[ScaleW-1:0];
        end
        CFG_ZERO_SPEED_GAP: begin
          gap_q <= cfg_wdata_i[TimeW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> hw/rtl/psm_div.sv
// Arithmetic unit: one 32x16 multiply, then a saturating
// restoring division by the elapsed time, one quotient bit per cycle.
// Depends on psm_pkg.
module psm_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  psm_pkg::psm_div_req_t req_i,
  output psm_pkg::psm_div_rsp_t rsp_o
);
  import psm_pkg::*;

  typedef enum logic [3:0] {
    D_IDLE = 4'b0001,
    D_MUL  = 4'b0010,
    D_CHK  = 4'b0100,
    D_DIV  = 4'b1000
  } div_state_e;

  div_state_e         state_q, state_d;
  logic [StepW-1:0]   step_q, step_d;
  logic               done_q, done_d;

  logic [ScaleW-1:0]  scale_q, scale_d;
  logic [CountW-1:0]  count_q, count_d;
  logic [TimeW-1:0]   den_q, den_d;
  logic [ProdW-1:0]   prod_q, prod_d;
  logic [TimeW-1:0]   rem_q, rem_d;
  logic [SpeedW-1:0]  quo_q, quo_d;

  logic [TimeW:0]     trial;
  logic [TimeW:0]     diff;
  logic               fits;

  // One subtract per cycle: the partial remainder with the next dividend bit.
  assign trial = {rem_q, quo_q[SpeedW-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    done_d  = 1'b0;
    scale_d = scale_q;
    count_d = count_q;
    den_d   = den_q;
    prod_d  = prod_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    case (state_q)
      D_IDLE: begin
        if (req_i.start) begin
          scale_d = req_i.scale;
          count_d = req_i.count;
          den_d   = req_i.elapsed;
          state_d = D_MUL;
        end
      end
      D_MUL: begin
        prod_d  = ProdW'(scale_q) * ProdW'(count_q);
        state_d = D_CHK;
      end
      D_CHK: begin
        // The quotient exceeds 16 bits exactly when the upper product word
        // is not below the divisor. A zero divisor always lands here too.
        if (prod_q[ProdW-1:TimeW] >= {{(ProdW-2*TimeW){1'b0}}, den_q}) begin
          quo_d   = SPEED_SAT;
          done_d  = 1'b1;
          state_d = D_IDLE;
        end else begin
          rem_d   = prod_q[2*TimeW-1:TimeW];
          quo_d   = prod_q[TimeW-1:0];
          step_d  = '0;
          state_d = D_DIV;
        end
      end
      D_DIV: begin
        rem_d  = fits ? diff[TimeW-1:0] : trial[TimeW-1:0];
        quo_d  = {quo_q[SpeedW-2:0], fits};
        step_d = step_q + 1'b1;
        if (step_q == StepW'(DivSteps - 1)) begin
          done_d  = 1'b1;
          state_d = D_IDLE;
        end
      end
      default: begin
        state_d = D_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      step_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scale_q <= scale_d;
    count_q <= count_d;
    den_q   <= den_d;
    prod_q  <= prod_d;
    rem_q   <= rem_d;
    quo_q   <= quo_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

>>> hw/rtl/psm_checker.sv
// Port-level checker for the pulse speed meter, bound to the top level.
// Depends on psm_pkg and pulse_speed_meter_top.
module psm_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input psm_pkg::psm_in_t  in_data_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input psm_pkg::psm_out_t out_data_o
);
  import psm_pkg::*;

  // A stalled result stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed or dropped");

  // No request is taken while a result is blocked.
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("request accepted while result is blocked");

  // A pulse answers in the next cycle and never reports an update.
  a_pulse_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_data_i.operation == OP_PULSE)
    |=> out_valid_o && !out_data_o.speed_updated)
    else $error("pulse result missing or flagged as update");

  // A reported speed is either zero or at least 1 km/h.
  a_speed_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.speed == '0) || (out_data_o.speed >= MIN_MOVING))
    else $error("speed between zero and 1 km/h");

endmodule

bind pulse_speed_meter_top psm_checker u_psm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

>>> tb/tb.sv
// Self-checking testbench for pulse_speed_meter_top: a directed table, a count saturation
// burst and random phases of wheel pulses and compute ticks under random idling.
// Depends on psm_pkg and the pulse_speed_meter_top RTL.
`timescale 1ns / 100ps

module tb;
  import psm_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  // Outlasts the slowest request, a full division, so it covers one with no sign of work.
  localparam int unsigned DRAIN_CYCLES = 24;

  typedef enum logic [1:0] {
    ROW_REQ,
    ROW_KNOWN,
    ROW_REG
  } row_kind_e;

  // One line of the directed table: a register write, a request checked against the
  // predictor, or a request whose result is written out by hand.
  typedef struct {
    row_kind_e           kind;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgW-1:0]     wdata;
    psm_in_t             req;
    psm_out_t            res;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  psm_in_t    in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  psm_out_t   out_data;
  logic       cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = '0;
  logic [CfgW-1:0]    cfg_wdata = '0;

  int unsigned cycle_cnt = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned send_gap_max = 14;
  int unsigned recv_gap_max = 14;

  psm_out_t expected_readings[$];

  // Predicted state of the meter and its registers.
  logic [ScaleW-1:0] pred_scale = '0;
  logic [TimeW-1:0]  pred_gap = 16'hFFFF;
  logic [TimeW-1:0]  pred_last = '0;
  logic [TimeW-1:0]  pred_prev = '0;
  logic [CountW-1:0] pred_count = '0;
  logic [SpeedW-1:0] pred_speed = '0;
  logic [MileW-1:0]  pred_miles = '0;

  pulse_speed_meter_top i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Saturating quotient scale * pulses / elapsed; a zero elapsed time saturates too.
  function automatic logic [SpeedW-1:0] pulse_rate(logic [CountW-1:0] pulses,
                                                   logic [TimeW-1:0] elapsed);
    logic [63:0] q;
    if (elapsed == '0) return SPEED_SAT;
    q = (64'(pred_scale) * 64'(pulses)) / 64'(elapsed);
    return (q > 64'(SPEED_SAT)) ? SPEED_SAT : q[SpeedW-1:0];
  endfunction

  // Advances the predicted meter by one request and returns the reading it should give.
  function automatic psm_out_t meter_step(psm_in_t req);
    psm_out_t          res;
    logic [TimeW-1:0]  stamp;
    logic [TimeW-1:0]  prev;
    logic [CountW-1:0] cnt;
    logic [SpeedW-1:0] spd;
    logic              moving;
    logic              keep;
    res = '0;
    if (req.operation == OP_PULSE) begin
      pred_last = req.timer_now;
      if (pred_count != COUNT_MAX) pred_count = pred_count + 1'b1;
    end else begin
      stamp = pred_last;
      cnt = pred_count;
      moving = (cnt != '0);
      spd = '0;
      keep = 1'b1;
      pred_count = '0;
      if (moving || pred_speed != '0) begin
        prev = pred_prev;
        if (moving) begin
          pred_miles = pred_miles + MileW'(cnt);
          pred_prev = stamp;
        end else begin
          // With no pulses the tick pretends one pulse arrived right now.
          cnt = CountW'(1);
          stamp = req.timer_now;
        end
        spd = pulse_rate(cnt, stamp - prev);
      end
      if (moving) begin
        if (spd < MIN_MOVING) spd = MIN_MOVING;
      end else if (spd < MIN_MOVING) begin
        spd = '0;
        pred_prev = stamp - pred_gap;
      end else if (spd > pred_speed) begin
        // An idle tick may only lower the speed.
        keep = 1'b0;
      end
      if (keep) begin
        pred_speed = spd;
        res.speed_updated = 1'b1;
      end
    end
    res.speed = pred_speed;
    res.mileage = pred_miles;
    return res;
  endfunction

  function automatic psm_in_t make_req(logic op, logic [TimeW-1:0] now);
    psm_in_t req;
    req.operation = op;
    req.timer_now = now;
    return req;
  endfunction

  function automatic stim_row_t req_row(logic op, logic [TimeW-1:0] now);
    stim_row_t row;
    row.kind = ROW_REQ;
    row.idx = '0;
    row.wdata = '0;
    row.req = make_req(op, now);
    row.res = '0;
    return row;
  endfunction

  function automatic stim_row_t known_row(logic op, logic [TimeW-1:0] now,
                                         logic [SpeedW-1:0] spd, logic [MileW-1:0] miles,
                                         logic upd);
    stim_row_t row;
    row = req_row(op, now);
    row.kind = ROW_KNOWN;
    row.res.speed = spd;
    row.res.mileage = miles;
    row.res.speed_updated = upd;
    return row;
  endfunction

  function automatic stim_row_t reg_row(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
    stim_row_t row;
    row = req_row(OP_PULSE, '0);
    row.kind = ROW_REG;
    row.idx = idx;
    row.wdata = data;
    return row;
  endfunction

  // Lowers valid and waits until every reading has come back and the block is quiet.
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
    settle();
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_SPEED_SCALE) pred_scale = data;
    else pred_gap = data[TimeW-1:0];
    @(posedge clk);
  endtask

  // Offers one request after a random gap and records its reading once accepted.
  // Valid stays high after acceptance so back-to-back requests need not raise it again.
  task automatic send_request(psm_in_t req, bit known, psm_out_t known_res);
    int unsigned gap;
    psm_out_t    res;
    gap = $urandom_range(0, send_gap_max);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (in_stall);
    res = meter_step(req);
    expected_readings.push_back(known ? known_res : res);
  endtask

  task automatic check_reading(psm_out_t got);
    psm_out_t want;
    if (expected_readings.size() == 0) begin
      $error("reading with no request outstanding: %h", got);
      mismatch_cnt++;
      return;
    end
    want = expected_readings.pop_front();
    if (got.speed !== want.speed) begin
      $error("speed: expected %0d, got %0d", want.speed, got.speed);
      mismatch_cnt++;
    end
    if (got.mileage !== want.mileage) begin
      $error("mileage: expected %0d, got %0d", want.mileage, got.mileage);
      mismatch_cnt++;
    end
    if (got.speed_updated !== want.speed_updated) begin
      $error("speed_updated: expected %0d, got %0d", want.speed_updated,
             got.speed_updated);
      mismatch_cnt++;
    end
  endtask

  // Result side: stalls for a random number of cycles before each reading.
  initial begin : reading_sink
    int unsigned hold;
    forever begin
      hold = $urandom_range(0, recv_gap_max);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
      check_reading(out_data);
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("pulse_speed_meter_top regression: fail");
      $finish;
    end
  end

  initial begin : stimulus
    stim_row_t         rows[$];
    psm_in_t           req;
    int unsigned       period;
    logic [TimeW-1:0]  wheel_clock;
    logic [TimeW-1:0]  gap_val;
    logic [ScaleW-1:0] scale_val;

    rows = '{
      // Reset registers: scale 0 and the widest zero-speed gap.
      known_row(OP_TICK, 16'h0000, '0, 0, 1'b1),           // idle and already stopped
      known_row(OP_PULSE, 16'hFFFF, '0, 0, 1'b0),
      known_row(OP_TICK, 16'h0000, MIN_MOVING, 1, 1'b1),   // pulses clamp to 1 km/h
      known_row(OP_TICK, 16'h1234, '0, 1, 1'b1),           // idle and slowing to zero
      // Largest scale with a gap of one: zero elapsed time and quotient overflow.
      reg_row(CFG_SPEED_SCALE, 32'hFFFF_FFFF),
      reg_row(CFG_ZERO_SPEED_GAP, 32'd1),
      known_row(OP_PULSE, 16'h1235, '0, 1, 1'b0),
      known_row(OP_TICK, 16'h2000, SPEED_SAT, 2, 1'b1),
      known_row(OP_TICK, 16'h1236, SPEED_SAT, 2, 1'b1),
      // Moderate settings: one km/h every 2000 ticks.
      reg_row(CFG_SPEED_SCALE, 32'd200000),
      reg_row(CFG_ZERO_SPEED_GAP, 32'd2000),
      req_row(OP_PULSE, 16'h3000),
      req_row(OP_PULSE, 16'h3010),
      req_row(OP_TICK, 16'h3020),
      req_row(OP_PULSE, 16'h3100),
      req_row(OP_TICK, 16'h3105),
      req_row(OP_TICK, 16'h3106),                          // idle and faster: kept
      req_row(OP_TICK, 16'h3300),                          // idle, slower but moving
      req_row(OP_TICK, 16'hF000),
      req_row(OP_TICK, 16'hF001),
      // A zero gap back-dates the previous stamp by nothing.
      reg_row(CFG_ZERO_SPEED_GAP, 32'd0),
      reg_row(CFG_SPEED_SCALE, 32'd100),
      req_row(OP_PULSE, 16'h0010),
      req_row(OP_TICK, 16'h0020),
      req_row(OP_TICK, 16'h8000),
      req_row(OP_TICK, 16'h8001),
      reg_row(CFG_ZERO_SPEED_GAP, 32'd65535),
      reg_row(CFG_SPEED_SCALE, 32'h8000_0000),
      req_row(OP_PULSE, 16'hAAAA),
      req_row(OP_PULSE, 16'h5555),
      req_row(OP_TICK, 16'hFFFF)
    };

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      case (rows[i].kind)
        ROW_REG: begin
          write_reg(rows[i].idx, rows[i].wdata);
        end
        ROW_KNOWN: begin
          send_request(rows[i].req, 1'b1, rows[i].res);
        end
        default: begin
          send_request(rows[i].req, 1'b0, '0);
        end
      endcase
    end

    // Drive the pulse count past its ceiling at full rate, then collect it with a tick.
    send_gap_max = 0;
    recv_gap_max = 0;
    for (int n = 0; n <= int'(COUNT_MAX) + 1; n++) begin
      send_request(make_req(OP_PULSE, 16'(n)), 1'b0, '0);
    end
    send_request(make_req(OP_TICK, 16'hFFFF), 1'b0, '0);

    // Random phases: mostly a wheel turning at a phase-wide rate on an advancing timer,
    // with some requests carrying arbitrary timer values.
    wheel_clock = 16'($urandom);
    for (int ph = 0; ph < 10; ph++) begin
      case ($urandom_range(0, 4))
        0: gap_val = 16'd1;
        1: gap_val = 16'hFFFF;
        2: gap_val = 16'd0;
        default: gap_val = 16'($urandom_range(200, 8000));
      endcase
      case ($urandom_range(0, 5))
        0: scale_val = '0;
        1: scale_val = 32'hFFFF_FFFF;
        2: scale_val = $urandom;
        default: scale_val = 32'(100 * gap_val * $urandom_range(1, 50));
      endcase
      write_reg(CFG_ZERO_SPEED_GAP, 32'(gap_val));
      write_reg(CFG_SPEED_SCALE, scale_val);
      send_gap_max = (ph % 3 == 2) ? 0 : 14;
      recv_gap_max = (ph % 4 == 3) ? 0 : 14;
      period = $urandom_range(1, 3000);
      for (int k = 0; k < 50; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          req.operation = 1'($urandom_range(0, 1));
          req.timer_now = 16'($urandom);
        end else begin
          req.operation = ($urandom_range(0, 3) == 0) ? OP_TICK : OP_PULSE;
          if (req.operation == OP_PULSE)
            wheel_clock += 16'($urandom_range(period / 2, period + period / 2));
          else
            wheel_clock += 16'($urandom_range(0, 2 * period));
          // Now and then the wheel stops for a while.
          if ($urandom_range(0, 19) == 0) wheel_clock += 16'($urandom);
          req.timer_now = wheel_clock;
        end
        send_request(req, 1'b0, '0);
      end
    end

    settle();
    if (mismatch_cnt == 0) begin
      $display("pulse_speed_meter_top regression: pass");
    end else begin
      $display("pulse_speed_meter_top regression: fail");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/psm_pkg.sv
hw/rtl/psm_div.sv
hw/rtl/pulse_speed_meter_top.sv
hw/rtl/psm_checker.sv
tb/tb.sv
